[rtl/sql_token_scanner_assert.svh]
// Assertion macros shared by the SQL token scanner modules.
`ifndef SQL_TOKEN_SCANNER_ASSERT_SVH
`define SQL_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sql token scanner: assertion failed");

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sql token scanner: assertion failed");

`endif

[rtl/sts_pkg.sv]
// Package with types, codes and tables of the SQL token scanner.
package sts_pkg;

  localparam int unsigned PosWidth  = 16;
  localparam int unsigned TypeWidth = 5;
  localparam int unsigned HeadWidth = 56;
  localparam int unsigned KwCount   = 13;
  localparam int unsigned PunctCount = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // scan mode codes
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeWord  = 2'd1;
  localparam logic [1:0] ModeNum   = 2'd2;
  localparam logic [1:0] ModeQuote = 2'd3;

  // token type codes (keywords are 0 .. KwCount-1)
  localparam logic [TypeWidth-1:0] TokIdent     = 5'd13;
  localparam logic [TypeWidth-1:0] TokInt       = 5'd14;
  localparam logic [TypeWidth-1:0] TokText      = 5'd15;
  localparam logic [TypeWidth-1:0] TokBad       = 5'd16;
  localparam logic [TypeWidth-1:0] TokUnterm    = 5'd17;
  localparam logic [TypeWidth-1:0] TokPunctBase = 5'd18;
  localparam logic [TypeWidth-1:0] TokEnd       = 5'd26;

  localparam logic [7:0] CharQuote = 8'h27;

  // first seven upper-case characters, first character in the highest used byte
  localparam logic [HeadWidth-1:0] KwText [KwCount] = '{
    56'h00_5345_4C45_4354, // SELECT
    56'h00_0000_4652_4F4D, // FROM
    56'h00_0057_4845_5245, // WHERE
    56'h00_494E_5345_5254, // INSERT
    56'h00_0000_494E_544F, // INTO
    56'h00_5641_4C55_4553, // VALUES
    56'h00_4352_4541_5445, // CREATE
    56'h00_0054_4142_4C45, // TABLE
    56'h00_0049_4E4E_4552, // INNER
    56'h00_0000_4A4F_494E, // JOIN
    56'h00_0000_0000_4F4E, // ON
    56'h44_4543_494D_414C, // DECIMAL
    56'h56_4152_4348_4152  // VARCHAR
  };

  localparam logic [7:0] PunctChar [PunctCount] = '{
    8'h28, 8'h29, 8'h2C, 8'h3D, 8'h3E, 8'h2E, 8'h3B, 8'h2A
  };

  typedef struct packed {
    logic [TypeWidth-1:0] tok_type;
    logic [PosWidth-1:0]  start_pos;
    logic [PosWidth-1:0]  tok_len;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic [TypeWidth-1:0] word_type(input logic [HeadWidth-1:0] head,
                                                     input logic too_long);
    logic [TypeWidth-1:0] t;
    logic                 hit;
    t   = TokIdent;
    hit = 1'b0;
    for (int unsigned i = 0; i < KwCount; i++) begin
      if (!too_long && !hit && head == KwText[i]) begin
        t   = TypeWidth'(i);
        hit = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic logic [TypeWidth-1:0] punct_type(input logic [7:0] c);
    logic [TypeWidth-1:0] t;
    t = TokBad;
    for (int unsigned i = 0; i < PunctCount; i++) begin
      if (c == PunctChar[i]) begin
        t = TokPunctBase + TypeWidth'(i);
      end
    end
    return t;
  endfunction

endpackage

[rtl/sql_token_scanner.sv]
// Top level of the SQL token scanner: byte stream in, token stream out.
//
//   channel  dir  tdata                                  tuser        tlast
//   s_axis   in   [7:0] char_code                        [0] is_end   -
//   m_axis   out  [15:0] start_pos, [31:16] token_length [4:0] type   last
//
// One byte word is taken per cycle; each word yields zero, one or two tokens.
// The path from input word to first token runs through the input register, then
// the scan logic writes the four-entry result queue whose head drives m_axis.
// A word giving two tokens is handed out token by token, so the queue sets the rate
// when such words follow closely; input stalls while the queue has under two free slots.
// Reset clears the scan state; the end word also returns it to its reset state.
module sql_token_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser_i,   // [0] is_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] start_pos, [31:16] token_length
  output logic [4:0]  m_axis_tuser_o,   // [4:0] token_type
  output logic        m_axis_tlast_o
);

  sts_pkg::push_t  push;
  sts_pkg::token_t tok;
  logic            room;

  sts_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .is_end_i  (s_axis_tuser_i[0]),
    .char_i    (s_axis_tdata_i),
    .room_i    (room),
    .push_o    (push)
  );

  sts_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .tok_o     (tok)
  );

  assign m_axis_tdata_o = {tok.tok_len, tok.start_pos};
  assign m_axis_tuser_o = tok.tok_type;
  assign m_axis_tlast_o = tok.last;

endmodule

[rtl/sts_core.sv]
// Input word register, scan state and per-byte token logic.
`include "sql_token_scanner_assert.svh"

module sts_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic          is_end_i,
  input  logic [7:0]    char_i,
  input  logic          room_i,
  output sts_pkg::push_t push_o
);

  logic                            in_valid_q;
  logic                            in_end_q;
  logic [7:0]                      in_char_q;
  logic                            fire;

  logic [1:0]                      mode_q, mode_d, mode_a;
  logic [sts_pkg::PosWidth-1:0]    pos_q, pos_d;
  logic [sts_pkg::PosWidth-1:0]    tstart_q, tstart_d;
  logic [sts_pkg::HeadWidth-1:0]   head_q, head_d;
  logic                            too_long_q, too_long_d;

  logic [sts_pkg::PosWidth-1:0]    span;
  logic [7:0]                      c, up;
  logic                            is_space, is_digit, is_alpha, is_wchar;
  logic                            flush_v, single_v;
  sts_pkg::token_t                 flush_tok, single_tok;

  assign fire      = in_valid_q & room_i;
  assign s_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_ready_o) begin
      in_valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_end_q  <= is_end_i;
      in_char_q <= char_i;
    end
  end

  assign c        = in_char_q;
  assign is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign is_wchar = is_alpha || is_digit || (c == 8'h5F);
  assign up       = ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'd32 : c;
  assign span     = (pos_q >= tstart_q) ? pos_q - tstart_q : '0;

  always_comb begin
    mode_d     = mode_q;
    mode_a     = mode_q;
    pos_d      = pos_q;
    tstart_d   = tstart_q;
    head_d     = head_q;
    too_long_d = too_long_q;
    flush_v    = 1'b0;
    single_v   = 1'b0;
    flush_tok  = '0;
    single_tok = '0;

    if (in_end_q) begin
      flush_tok.start_pos = tstart_q;
      unique case (mode_q)
        sts_pkg::ModeWord: begin
          flush_v            = 1'b1;
          flush_tok.tok_type = sts_pkg::word_type(head_q, too_long_q);
          flush_tok.tok_len  = span;
        end
        sts_pkg::ModeNum: begin
          flush_v            = 1'b1;
          flush_tok.tok_type = sts_pkg::TokInt;
          flush_tok.tok_len  = span;
        end
        sts_pkg::ModeQuote: begin
          flush_v            = 1'b1;
          flush_tok.tok_type = sts_pkg::TokUnterm;
        end
        default: begin
          flush_v = 1'b0;
        end
      endcase
      single_v             = 1'b1;
      single_tok.tok_type  = sts_pkg::TokEnd;
      single_tok.start_pos = pos_q;
      single_tok.last      = 1'b1;
      mode_d               = sts_pkg::ModeIdle;
      pos_d                = '0;
      tstart_d             = '0;
      head_d               = '0;
      too_long_d           = 1'b0;
    end else begin
      pos_d = (pos_q != {sts_pkg::PosWidth{1'b1}}) ? pos_q + sts_pkg::PosWidth'(1) : pos_q;
      if (mode_q == sts_pkg::ModeQuote) begin
        if (c == sts_pkg::CharQuote) begin
          flush_v             = 1'b1;
          flush_tok.tok_type  = sts_pkg::TokText;
          flush_tok.start_pos = tstart_q;
          flush_tok.tok_len   = (span != '0) ? span - sts_pkg::PosWidth'(1) : '0;
          mode_d              = sts_pkg::ModeIdle;
        end
      end else begin
        if (mode_q == sts_pkg::ModeWord) begin
          if (is_wchar) begin
            if (head_q[sts_pkg::HeadWidth-1 -: 8] != 8'd0) begin
              too_long_d = 1'b1;
            end else begin
              head_d = {head_q[sts_pkg::HeadWidth-9:0], up};
            end
          end else begin
            flush_v             = 1'b1;
            flush_tok.tok_type  = sts_pkg::word_type(head_q, too_long_q);
            flush_tok.start_pos = tstart_q;
            flush_tok.tok_len   = span;
            mode_a              = sts_pkg::ModeIdle;
          end
        end else if (mode_q == sts_pkg::ModeNum && !is_digit) begin
          flush_v             = 1'b1;
          flush_tok.tok_type  = sts_pkg::TokInt;
          flush_tok.start_pos = tstart_q;
          flush_tok.tok_len   = span;
          mode_a              = sts_pkg::ModeIdle;
        end
        mode_d = mode_a;
        if (mode_a == sts_pkg::ModeIdle && !is_space) begin
          tstart_d = pos_q;
          if (is_alpha || c == 8'h5F) begin
            mode_d     = sts_pkg::ModeWord;
            head_d     = {{(sts_pkg::HeadWidth-8){1'b0}}, up};
            too_long_d = 1'b0;
          end else if (is_digit) begin
            mode_d = sts_pkg::ModeNum;
          end else if (c == sts_pkg::CharQuote) begin
            mode_d = sts_pkg::ModeQuote;
          end else begin
            single_v             = 1'b1;
            single_tok.tok_type  = sts_pkg::punct_type(c);
            single_tok.start_pos = pos_q;
            single_tok.tok_len   = sts_pkg::PosWidth'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sts_pkg::ModeIdle;
      pos_q      <= '0;
      tstart_q   <= '0;
      head_q     <= '0;
      too_long_q <= 1'b0;
    end else if (fire) begin
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      tstart_q   <= tstart_d;
      head_q     <= head_d;
      too_long_q <= too_long_d;
    end
  end

  always_comb begin
    push_o.cnt  = fire ? ({1'b0, flush_v} + {1'b0, single_v}) : 2'd0;
    push_o.tok0 = flush_v ? flush_tok : single_tok;
    push_o.tok1 = single_tok;
  end

  `STS_ASSERT_NEXT(a_end_clears_state, clk_i, rst_ni, fire && in_end_q, mode_q == sts_pkg::ModeIdle && pos_q == '0)
  `STS_ASSERT_IMPL(a_push_only_on_fire, clk_i, rst_ni, !fire, push_o.cnt == 2'd0)
  `STS_ASSERT_IMPL(a_quote_single_word, clk_i, rst_ni, fire && !in_end_q && mode_q == sts_pkg::ModeQuote, push_o.cnt != 2'd2)

endmodule

[rtl/sts_fifo.sv]
// Result queue: takes up to two tokens a cycle, hands out one.
`include "sql_token_scanner_assert.svh"

module sts_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sts_pkg::push_t  push_i,
  output logic            room_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output sts_pkg::token_t tok_o
);

  sts_pkg::token_t                 mem_q [sts_pkg::FifoDepth];
  logic [sts_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [sts_pkg::FifoCntW-1:0]    count_q;
  logic                            pop;

  assign m_valid_o = (count_q != '0);
  assign pop       = m_valid_o && m_ready_i;
  assign room_o    = (count_q <= sts_pkg::FifoCntW'(sts_pkg::FifoDepth - 2));
  assign tok_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + sts_pkg::FifoPtrW'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + sts_pkg::FifoPtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + sts_pkg::FifoPtrW'(pop);
      count_q  <= count_q + sts_pkg::FifoCntW'(push_i.cnt) - sts_pkg::FifoCntW'(pop);
    end
  end

  `STS_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i.cnt != 2'd0, int'(count_q) + int'(push_i.cnt) <= int'(sts_pkg::FifoDepth))
  `STS_ASSERT_IMPL(a_last_is_end, clk_i, rst_ni, m_valid_o && tok_o.last, tok_o.tok_type == sts_pkg::TokEnd)
  `STS_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && push_i.cnt == 2'd0, count_q == $past(count_q) - sts_pkg::FifoCntW'(1))

endmodule

[verif/tb_sql_token_scanner.sv]
// Testbench for the SQL token scanner: directed and random query texts checked against a token predictor.

class token_scoreboard;
  sts_pkg::token_t expected_q[$];
  string           kw_text[13];
  string           punct_text = "(),=>.;*";
  int unsigned     errors;
  logic [1:0]      mode;
  logic [15:0]     pos;
  logic [15:0]     tok_start;
  logic [55:0]     head;
  bit              too_long;
  logic [55:0]     kw_head[13];

  function new();
    kw_text = '{"SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE",
                "TABLE", "INNER", "JOIN", "ON", "DECIMAL", "VARCHAR"};
    foreach (kw_text[i]) kw_head[i] = pack_head(kw_text[i]);
    errors = 0;
    clear_scan();
  endfunction

  function logic [55:0] pack_head(string s);
    logic [55:0] v;
    v = '0;
    for (int i = 0; i < 7 && i < s.len(); i++) v = {v[47:0], s[i]};
    return v;
  endfunction

  function void clear_scan();
    mode      = sts_pkg::ModeIdle;
    pos       = '0;
    tok_start = '0;
    head      = '0;
    too_long  = 1'b0;
  endfunction

  function bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function bit is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5F;
  endfunction

  function void add_char(logic [7:0] c);
    logic [7:0] up;
    up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    if (head[55:48] != 8'h00) too_long = 1'b1;
    else head = {head[47:0], up};
  endfunction

  function logic [15:0] span();
    return pos >= tok_start ? pos - tok_start : 16'd0;
  endfunction

  function logic [4:0] word_kind();
    for (int i = 0; i < 13; i++) begin
      if (!too_long && head == kw_head[i]) return 5'(i);
    end
    return sts_pkg::TokIdent;
  endfunction

  function void push(logic [4:0] kind, logic [15:0] start, logic [15:0] len, logic last);
    sts_pkg::token_t t;
    t.tok_type  = kind;
    t.start_pos = start;
    t.tok_len   = len;
    t.last      = last;
    expected_q.insert(expected_q.size(), t);
  endfunction

  // expected tokens for one accepted byte word
  function void take_byte(bit is_end, logic [7:0] c);
    logic [15:0] len;
    logic [4:0]  kind;
    if (is_end) begin
      case (mode)
        sts_pkg::ModeWord: push(word_kind(), tok_start, span(), 1'b0);
        sts_pkg::ModeNum: push(sts_pkg::TokInt, tok_start, span(), 1'b0);
        sts_pkg::ModeQuote: push(sts_pkg::TokUnterm, tok_start, 16'd0, 1'b0);
        default: ;
      endcase
      push(sts_pkg::TokEnd, pos, 16'd0, 1'b1);
      clear_scan();
      return;
    end
    if (mode == sts_pkg::ModeQuote) begin
      if (c == sts_pkg::CharQuote) begin
        len = span();
        push(sts_pkg::TokText, tok_start, (len != 16'd0) ? len - 16'd1 : 16'd0, 1'b0);
        mode = sts_pkg::ModeIdle;
      end
    end else begin
      if (mode == sts_pkg::ModeWord) begin
        if (is_word(c)) begin
          add_char(c);
        end else begin
          push(word_kind(), tok_start, span(), 1'b0);
          mode = sts_pkg::ModeIdle;
        end
      end else if (mode == sts_pkg::ModeNum && !is_digit(c)) begin
        push(sts_pkg::TokInt, tok_start, span(), 1'b0);
        mode = sts_pkg::ModeIdle;
      end
      if (mode == sts_pkg::ModeIdle && !is_space(c)) begin
        tok_start = pos;
        if (is_alpha(c) || c == 8'h5F) begin
          mode     = sts_pkg::ModeWord;
          head     = '0;
          too_long = 1'b0;
          add_char(c);
        end else if (is_digit(c)) begin
          mode = sts_pkg::ModeNum;
        end else if (c == sts_pkg::CharQuote) begin
          mode = sts_pkg::ModeQuote;
        end else begin
          kind = sts_pkg::TokBad;
          for (int i = 0; i < 8; i++) begin
            if (c == punct_text[i]) kind = sts_pkg::TokPunctBase + 5'(i);
          end
          push(kind, pos, 16'd1, 1'b0);
        end
      end
    end
    if (pos != 16'hFFFF) pos++;
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function void check_token(sts_pkg::token_t got);
    sts_pkg::token_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected token: expected none, actual type %0d start %0d length %0d",
               $time, got.tok_type, got.start_pos, got.tok_len);
      return;
    end
    want = expected_q.pop_front();
    compare("token_type", 16'(want.tok_type), 16'(got.tok_type));
    compare("start_pos", want.start_pos, got.start_pos);
    compare("token_length", want.tok_len, got.tok_len);
    compare("last", 16'(want.last), 16'(got.last));
  endfunction
endclass

module tb_sql_token_scanner;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  token_scoreboard sb = new();
  logic [7:0]      query[$];
  bit              quiet = 1'b0;
  int unsigned     words_sent = 0;

  sql_token_scanner u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_word_char(bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(8'h41 + r);
    if (r < 52) return 8'(8'h61 + r - 26);
    if (r == 52) return 8'h5F;
    return 8'(8'h30 + r - 53);
  endfunction

  function automatic logic [7:0] rand_space();
    int unsigned r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'd32 : 8'(r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    query.insert(query.size(), b);
  endfunction

  function automatic void push_string(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // one random token plus an optional separator
  function automatic void append_token();
    int unsigned pick;
    string       kw;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      kw = sb.kw_text[$urandom_range(0, 12)];
      for (int i = 0; i < kw.len(); i++) begin
        ch = kw[i];
        if ($urandom_range(0, 1) == 1) ch = ch + 8'd32;
        add_byte(ch);
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(rand_word_char(1'b0));
      end
    end else if (pick < 45) begin
      add_byte(rand_word_char(1'b1));
      repeat ($urandom_range(0, 11)) add_byte(rand_word_char(1'b0));
    end else if (pick < 58) begin
      repeat ($urandom_range(1, 6)) add_byte(8'(8'h30 + $urandom_range(0, 9)));
    end else if (pick < 68) begin
      add_byte(sts_pkg::CharQuote);
      repeat ($urandom_range(0, 6)) begin
        do ch = 8'($urandom_range(0, 255)); while (ch == sts_pkg::CharQuote);
        add_byte(ch);
      end
      add_byte(sts_pkg::CharQuote);
    end else if (pick < 88) begin
      add_byte(sb.punct_text[$urandom_range(0, 7)]);
    end else if (pick < 94) begin
      add_byte(8'($urandom_range(128, 255)));
    end else begin
      do ch = 8'($urandom_range(0, 127));
      while (sb.is_word(ch) || sb.is_space(ch) || ch == sts_pkg::CharQuote);
      add_byte(ch);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      add_byte(rand_space());
    end else if (pick < 8) begin
      add_byte(rand_space());
      add_byte(rand_space());
    end
  endfunction

  task automatic send_word(bit is_end, logic [7:0] ch);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tuser_i  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_byte(is_end, ch);
    words_sent++;
  endtask

  task automatic send_query(logic [7:0] end_char);
    foreach (query[i]) send_word(1'b0, query[i]);
    query.delete();
    send_word(1'b1, end_char);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // token sink with random back-pressure
  initial begin
    sts_pkg::token_t got;
    int unsigned     stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.tok_type  = m_axis_tuser_o;
        got.start_pos = m_axis_tdata_o[15:0];
        got.tok_len   = m_axis_tdata_o[31:16];
        got.last      = m_axis_tlast_o;
        sb.check_token(got);
      end
      if (stall > 0 && !quiet) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned random_start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // digits then letters, text, punctuation, bad and edge bytes
    push_string("12ab ('q'),=>.;*");
    add_byte(8'h00);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(8'h09);
    add_byte(8'h5F);
    send_query(8'hFF);
    send_query(8'h00);
    push_string("x 'ab");
    send_query(8'h5A);

    // long word, number, text and a bad byte with no gaps
    wait_drained();
    quiet = 1'b1;
    push_string("select_me 42 'xy' !");
    send_query(8'h00);
    quiet = 1'b0;
    wait_drained();

    random_start = words_sent;
    while (words_sent - random_start < 1100) begin
      pick  = $urandom_range(0, 99);
      quiet = (pick < 12);
      if (pick >= 95) begin
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 12)) append_token();
        if ($urandom_range(0, 11) == 0) begin
          add_byte(sts_pkg::CharQuote);
          repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
        end
      end
      send_query(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
